// File: rtl/lcdc_pkg.sv
// Shared types and command codes of the graphic LCD controller.
package lcdc_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } t_state;

    typedef enum logic [1:0] {
        BUS_CMD_WRITE  = 2'd0,
        BUS_DATA_WRITE = 2'd1,
        BUS_STATUS     = 2'd2,
        BUS_DATA_READ  = 2'd3
    } t_bus_cmd;

    localparam logic [3:0] GRP_COL_LO  = 4'h0;
    localparam logic [3:0] GRP_COL_HI  = 4'h1;
    localparam logic [3:0] GRP_DISPLAY = 4'h2;
    localparam logic [3:0] GRP_TIMER   = 4'h3;
    localparam logic [3:0] GRP_START_0 = 4'h4;
    localparam logic [3:0] GRP_START_1 = 4'h5;
    localparam logic [3:0] GRP_START_2 = 4'h6;
    localparam logic [3:0] GRP_START_3 = 4'h7;
    localparam logic [3:0] GRP_CONTR_0 = 4'h8;
    localparam logic [3:0] GRP_CONTR_1 = 4'h9;
    localparam logic [3:0] GRP_EFFECT  = 4'hA;
    localparam logic [3:0] GRP_PAGE    = 4'hB;
    localparam logic [3:0] GRP_TRIM    = 4'hC;
    localparam logic [3:0] GRP_MODIFY  = 4'hE;

    localparam logic [7:0] CMD_DISP_OFF     = 8'h24;
    localparam logic [7:0] CMD_DISP_ON      = 8'h25;
    localparam logic [7:0] CMD_MIRROR_OFF   = 8'hA0;
    localparam logic [7:0] CMD_MIRROR_ON    = 8'hA1;
    localparam logic [7:0] CMD_BLACK_OFF    = 8'hA4;
    localparam logic [7:0] CMD_BLACK_ON     = 8'hA5;
    localparam logic [7:0] CMD_REVERSE_OFF  = 8'hA6;
    localparam logic [7:0] CMD_REVERSE_ON   = 8'hA7;
    localparam logic [7:0] CMD_DARK_ON      = 8'hA8;
    localparam logic [7:0] CMD_DARK_OFF     = 8'hA9;
    localparam logic [7:0] CMD_WHITE_ON     = 8'hAE;
    localparam logic [7:0] CMD_WHITE_OFF    = 8'hAF;
    localparam logic [7:0] CMD_MODIFY_ENTER = 8'hE0;
    localparam logic [7:0] CMD_RESET_CONTR  = 8'hE2;
    localparam logic [7:0] CMD_MODIFY_LEAVE = 8'hEE;

    localparam int unsigned EFF_MIRROR  = 0;
    localparam int unsigned EFF_BLACK   = 1;
    localparam int unsigned EFF_REVERSE = 2;
    localparam int unsigned EFF_DARK    = 3;
    localparam int unsigned EFF_WHITE   = 4;

    localparam logic [7:0] READ_OUT_OF_RANGE = 8'hFF;
    localparam int unsigned TIMER_UNIT = 16192;

endpackage

// File: rtl/lcd_controller_with_rmw_mode.sv
// Top level of the graphic LCD controller with display memory and modify mode.
// Results are registered: a result is presented in the cycle after its beat is
// accepted; a data read from the display memory passes the RAM read register and ST_READ.
// Throughput: one beat per cycle while the output is not stalled; a memory data read
// holds off input in ST_READ. Reset: control registers clear, then the display memory
// is zeroed one entry per cycle, PAGES*COLUMNS entries (1328 by default), before a beat is taken.
module lcd_controller_with_rmw_mode #(
    parameter int COLUMNS = 166,
    parameter int PAGES   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] wdata
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // [7:0] rdata, [8] display_off, [14:9] start_line,
                                          // [19:15] contrast, [24:20] effect_flags,
                                          // [28:25] trim, [46:29] timer_interval
);
    import lcdc_pkg::*;

    localparam int DEPTH  = PAGES * COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state r_state, n_state;

    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [7:0]  r_column, n_column;
    logic [3:0]  r_page, n_page;
    logic [7:0]  r_saved_column, n_saved_column;
    logic        r_modify, n_modify;
    logic        r_primed, n_primed;
    logic        r_display_off, n_display_off;
    logic [5:0]  r_start_line, n_start_line;
    logic [4:0]  r_contrast, n_contrast;
    logic [4:0]  r_effect, n_effect;
    logic [3:0]  r_trim, n_trim;
    logic [3:0]  r_timer_sel, n_timer_sel;
    logic        r_out_valid, n_out_valid;
    logic [47:0] r_out_data, n_out_data;

    logic              w_accept;
    logic              w_out_free;
    logic              w_in_range;
    logic              w_clear_done;
    logic              w_mem_read;
    logic [ADDR_W-1:0] w_cell;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_addr;
    logic [7:0]        w_ram_wdata;
    logic [7:0]        w_ram_rdata;
    logic [17:0]       w_timer_cur;
    logic [17:0]       w_timer_next;
    t_bus_cmd          w_cmd;
    logic [7:0]        w_x;

    assign w_cmd        = t_bus_cmd'(i_s_axis_tuser);
    assign w_x          = i_s_axis_tdata;
    assign w_out_free   = !r_out_valid || i_m_axis_tready;
    assign w_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_range   = ({1'b0, r_column} < 9'(COLUMNS)) && ({1'b0, r_page} < 5'(PAGES));
    assign w_cell       = ADDR_W'(32'(r_page) * 32'(COLUMNS) + 32'(r_column));
    assign w_clear_done = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign w_mem_read   = w_accept && (w_cmd == BUS_DATA_READ) && r_primed && w_in_range;
    assign w_timer_cur  = 18'(32'(TIMER_UNIT) * (32'(r_timer_sel) + 32'd1));
    assign w_timer_next = 18'(32'(TIMER_UNIT) * (32'(n_timer_sel) + 32'd1));

    lcdc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (w_clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_mem_read) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_ram_we        = 1'b0;
        w_ram_addr      = w_cell;
        w_ram_wdata     = w_x;
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_clr_addr;
                w_ram_wdata = '0;
            end
            ST_IDLE: begin
                o_s_axis_tready = w_out_free;
                w_ram_we = i_s_axis_tvalid && w_out_free && (w_cmd == BUS_DATA_WRITE)
                    && w_in_range;
            end
            ST_READ: begin
                o_s_axis_tready = 1'b0;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        logic [7:0] v_rdata;
        v_rdata        = '0;
        n_clr_addr     = r_clr_addr;
        n_column       = r_column;
        n_page         = r_page;
        n_saved_column = r_saved_column;
        n_modify       = r_modify;
        n_primed       = r_primed;
        n_display_off  = r_display_off;
        n_start_line   = r_start_line;
        n_contrast     = r_contrast;
        n_effect       = r_effect;
        n_trim         = r_trim;
        n_timer_sel    = r_timer_sel;
        n_out_valid    = r_out_valid && !i_m_axis_tready;
        n_out_data     = r_out_data;

        if (r_state == ST_CLEAR) begin
            n_clr_addr = r_clr_addr + 1'b1;
        end

        if (r_state == ST_READ) begin
            n_out_valid = 1'b1;
            n_out_data  = {1'b0, w_timer_cur, r_trim, r_effect, r_contrast, r_start_line,
                           r_display_off, w_ram_rdata};
        end

        if (w_accept) begin
            unique case (w_cmd)
                BUS_CMD_WRITE: begin
                    n_primed = 1'b0;
                    case (w_x[7:4]) inside
                        GRP_COL_LO: begin
                            if (!r_modify) begin
                                n_column = {r_column[7:4], w_x[3:0]};
                            end
                        end
                        GRP_COL_HI: begin
                            if (!r_modify) begin
                                n_column = {w_x[3:0], r_column[3:0]};
                            end
                        end
                        GRP_DISPLAY: begin
                            if (w_x == CMD_DISP_OFF) begin
                                n_display_off = 1'b1;
                            end else if (w_x == CMD_DISP_ON) begin
                                n_display_off = 1'b0;
                            end
                        end
                        GRP_TIMER: begin
                            n_timer_sel = w_x[3:0];
                        end
                        GRP_START_0, GRP_START_1, GRP_START_2, GRP_START_3: begin
                            n_start_line = w_x[5:0];
                        end
                        GRP_CONTR_0, GRP_CONTR_1: begin
                            n_contrast = w_x[4:0];
                        end
                        GRP_EFFECT: begin
                            unique case (w_x)
                                CMD_MIRROR_OFF:  n_effect[EFF_MIRROR]  = 1'b0;
                                CMD_MIRROR_ON:   n_effect[EFF_MIRROR]  = 1'b1;
                                CMD_BLACK_OFF:   n_effect[EFF_BLACK]   = 1'b0;
                                CMD_BLACK_ON:    n_effect[EFF_BLACK]   = 1'b1;
                                CMD_REVERSE_OFF: n_effect[EFF_REVERSE] = 1'b0;
                                CMD_REVERSE_ON:  n_effect[EFF_REVERSE] = 1'b1;
                                CMD_DARK_ON:     n_effect[EFF_DARK]    = 1'b1;
                                CMD_DARK_OFF:    n_effect[EFF_DARK]    = 1'b0;
                                CMD_WHITE_ON:    n_effect[EFF_WHITE]   = 1'b1;
                                CMD_WHITE_OFF:   n_effect[EFF_WHITE]   = 1'b0;
                                default: begin
                                end
                            endcase
                        end
                        GRP_PAGE: begin
                            n_page = w_x[3:0];
                        end
                        GRP_TRIM: begin
                            n_trim = w_x[3:0];
                        end
                        GRP_MODIFY: begin
                            if (w_x == CMD_MODIFY_ENTER) begin
                                n_modify       = 1'b1;
                                n_saved_column = r_column;
                            end else if (w_x == CMD_RESET_CONTR) begin
                                n_contrast = '0;
                                n_modify   = 1'b0;
                            end else if (w_x == CMD_MODIFY_LEAVE) begin
                                n_modify = 1'b0;
                                n_column = r_saved_column;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                BUS_DATA_WRITE: begin
                    n_primed = 1'b0;
                    if (w_in_range) begin
                        n_column = r_column + 1'b1;
                    end
                end
                BUS_STATUS: begin
                end
                BUS_DATA_READ: begin
                    if (!r_primed) begin
                        n_primed = 1'b1;
                    end else begin
                        v_rdata = READ_OUT_OF_RANGE;
                        if (!r_modify) begin
                            n_column = r_column + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (!w_mem_read) begin
                n_out_valid = 1'b1;
                n_out_data  = {1'b0, w_timer_next, n_trim, n_effect, n_contrast, n_start_line,
                               n_display_off, v_rdata};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_addr     <= '0;
            r_column       <= '0;
            r_page         <= '0;
            r_saved_column <= '0;
            r_modify       <= 1'b0;
            r_primed       <= 1'b0;
            r_display_off  <= 1'b0;
            r_start_line   <= '0;
            r_contrast     <= '0;
            r_effect       <= '0;
            r_trim         <= '0;
            r_timer_sel    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr_addr     <= n_clr_addr;
            r_column       <= n_column;
            r_page         <= n_page;
            r_saved_column <= n_saved_column;
            r_modify       <= n_modify;
            r_primed       <= n_primed;
            r_display_off  <= n_display_off;
            r_start_line   <= n_start_line;
            r_contrast     <= n_contrast;
            r_effect       <= n_effect;
            r_trim         <= n_trim;
            r_timer_sel    <= n_timer_sel;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: rtl/lcdc_ram.sv
// Generic single-port synchronous RAM with registered read data.
module lcdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1328,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: test/tb_lcd_controller_with_rmw_mode.sv
// Self-checking stream testbench for the graphic LCD controller with modify mode.
`timescale 1ns / 100ps

module tb_lcd_controller_with_rmw_mode;
    import lcdc_pkg::*;

    localparam int N_COLS = 166;
    localparam int N_PAGES = 8;
    localparam int N_RANDOM_BEATS = 850;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [3:0] GRP_SPARE_D = 4'hD;
    localparam logic [3:0] GRP_SPARE_F = 4'hF;

    typedef struct {
        t_bus_cmd   op;
        logic [7:0] wdata;
    } t_bus_beat;

    typedef struct packed {
        logic        pad;
        logic [17:0] timer_interval;
        logic [3:0]  trim;
        logic [4:0]  effect_flags;
        logic [4:0]  contrast;
        logic [5:0]  start_line;
        logic        display_off;
        logic [7:0]  rdata;
    } t_lcd_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;

    lcd_controller_with_rmw_mode #(
        .COLUMNS(N_COLS),
        .PAGES  (N_PAGES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    t_bus_beat   pending_beats[$];
    t_lcd_result expected_results[$];
    int          n_errors = 0;
    int          n_accepted = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct;
    int          stall_pct;

    logic [7:0] lcd_ram [0:N_PAGES-1][0:N_COLS-1];
    logic [7:0] col_ptr = '0;
    logic [3:0] page_sel = '0;
    logic [7:0] saved_col = '0;
    logic       modify_on = 1'b0;
    logic       read_primed = 1'b0;
    logic       disp_off = 1'b0;
    logic [5:0] start_line = '0;
    logic [4:0] contrast = '0;
    logic [4:0] effects = '0;
    logic [3:0] trim = '0;
    logic [3:0] timer_sel = '0;

    wire [1:0] idle_phase = 2'((n_accepted / 100) % 4);
    assign send_idle_pct = (idle_phase == 2'd1) ? 65 : (idle_phase == 2'd3) ? 13 : 0;
    assign stall_pct     = (idle_phase == 2'd2) ? 65 : (idle_phase == 2'd3) ? 13 : 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one bus access to the shadow controller and returns the beat it must produce.
    function automatic t_lcd_result lcd_bus_access(t_bus_cmd op, logic [7:0] x);
        t_lcd_result r;
        logic        hit;
        r = '0;
        hit = (int'(col_ptr) < N_COLS) && (int'(page_sel) < N_PAGES);
        case (op)
            BUS_CMD_WRITE: begin
                read_primed = 1'b0;
                case (x[7:4])
                    GRP_COL_LO: if (!modify_on) col_ptr[3:0] = x[3:0];
                    GRP_COL_HI: if (!modify_on) col_ptr[7:4] = x[3:0];
                    GRP_DISPLAY: begin
                        if (x == CMD_DISP_OFF) disp_off = 1'b1;
                        else if (x == CMD_DISP_ON) disp_off = 1'b0;
                    end
                    GRP_TIMER: timer_sel = x[3:0];
                    GRP_START_0, GRP_START_1, GRP_START_2, GRP_START_3: start_line = x[5:0];
                    GRP_CONTR_0, GRP_CONTR_1: contrast = x[4:0];
                    GRP_EFFECT: begin
                        case (x)
                            CMD_MIRROR_OFF:  effects[EFF_MIRROR] = 1'b0;
                            CMD_MIRROR_ON:   effects[EFF_MIRROR] = 1'b1;
                            CMD_BLACK_OFF:   effects[EFF_BLACK] = 1'b0;
                            CMD_BLACK_ON:    effects[EFF_BLACK] = 1'b1;
                            CMD_REVERSE_OFF: effects[EFF_REVERSE] = 1'b0;
                            CMD_REVERSE_ON:  effects[EFF_REVERSE] = 1'b1;
                            CMD_DARK_ON:     effects[EFF_DARK] = 1'b1;
                            CMD_DARK_OFF:    effects[EFF_DARK] = 1'b0;
                            CMD_WHITE_ON:    effects[EFF_WHITE] = 1'b1;
                            CMD_WHITE_OFF:   effects[EFF_WHITE] = 1'b0;
                            default: ;
                        endcase
                    end
                    GRP_PAGE: page_sel = x[3:0];
                    GRP_TRIM: trim = x[3:0];
                    GRP_MODIFY: begin
                        if (x == CMD_MODIFY_ENTER) begin
                            modify_on = 1'b1;
                            saved_col = col_ptr;
                        end else if (x == CMD_RESET_CONTR) begin
                            contrast = '0;
                            modify_on = 1'b0;
                        end else if (x == CMD_MODIFY_LEAVE) begin
                            modify_on = 1'b0;
                            col_ptr = saved_col;
                        end
                    end
                    default: ;
                endcase
            end
            BUS_DATA_WRITE: begin
                read_primed = 1'b0;
                if (hit) begin
                    lcd_ram[page_sel][col_ptr] = x;
                    col_ptr = col_ptr + 8'd1;
                end
            end
            BUS_STATUS: ;
            default: begin
                if (!read_primed) begin
                    read_primed = 1'b1;
                end else begin
                    if (hit) r.rdata = lcd_ram[page_sel][col_ptr];
                    else r.rdata = READ_OUT_OF_RANGE;
                    if (!modify_on) col_ptr = col_ptr + 8'd1;
                end
            end
        endcase
        r.display_off = disp_off;
        r.start_line = start_line;
        r.contrast = contrast;
        r.effect_flags = effects;
        r.trim = trim;
        r.timer_interval = 18'(TIMER_UNIT * (int'(timer_sel) + 1));
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic push_beat(t_bus_cmd op, logic [7:0] x);
        t_bus_beat b;
        b.op = op;
        b.wdata = x;
        pending_beats.push_back(b);
    endtask

    task automatic push_cursor(logic [3:0] page, logic [7:0] col);
        push_beat(BUS_CMD_WRITE, {GRP_PAGE, page});
        push_beat(BUS_CMD_WRITE, {GRP_COL_HI, col[7:4]});
        push_beat(BUS_CMD_WRITE, {GRP_COL_LO, col[3:0]});
    endtask

    always @(posedge i_clk) begin : bus_driver
        t_bus_beat b;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(
                    lcd_bus_access(t_bus_cmd'(i_s_axis_tuser), i_s_axis_tdata));
                n_accepted <= n_accepted + 1;
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
            end else if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                b = pending_beats.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser <= b.op;
                i_s_axis_tdata <= b.wdata;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin : result_monitor
        t_lcd_result got;
        t_lcd_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_lcd_result'(o_m_axis_tdata);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat", int'(o_m_axis_tdata[31:0]), 0);
            end else begin
                want = expected_results.pop_front();
                if (got.rdata !== want.rdata)
                    report_mismatch("rdata", got.rdata, want.rdata);
                if (got.display_off !== want.display_off)
                    report_mismatch("display_off", got.display_off, want.display_off);
                if (got.start_line !== want.start_line)
                    report_mismatch("start_line", got.start_line, want.start_line);
                if (got.contrast !== want.contrast)
                    report_mismatch("contrast", got.contrast, want.contrast);
                if (got.effect_flags !== want.effect_flags)
                    report_mismatch("effect_flags", got.effect_flags, want.effect_flags);
                if (got.trim !== want.trim)
                    report_mismatch("trim", got.trim, want.trim);
                if (got.timer_interval !== want.timer_interval)
                    report_mismatch("timer_interval", got.timer_interval, want.timer_interval);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int         n_random;
        int         kind;
        int         burst;
        logic [3:0] page;
        logic [7:0] col;
        foreach (lcd_ram[p, c]) lcd_ram[p][c] = '0;

        // Dummy read after reset, then a real read of the cleared memory.
        push_beat(BUS_DATA_READ, 8'($urandom));
        push_beat(BUS_DATA_READ, 8'($urandom));
        push_beat(BUS_STATUS, 8'($urandom));
        push_beat(BUS_CMD_WRITE, {GRP_SPARE_F, 4'hF});
        // Column 0xFF is out of range: writes are dropped, reads return all ones and wrap.
        push_beat(BUS_CMD_WRITE, {GRP_COL_HI, 4'hF});
        push_beat(BUS_CMD_WRITE, {GRP_COL_LO, 4'hF});
        push_beat(BUS_DATA_WRITE, 8'hFF);
        push_beat(BUS_DATA_READ, 8'($urandom));
        push_beat(BUS_DATA_READ, 8'($urandom));
        push_beat(BUS_CMD_WRITE, {GRP_PAGE, 4'hF});
        push_beat(BUS_DATA_WRITE, 8'h00);
        push_cursor(4'd7, 8'(N_COLS - 1));
        push_beat(BUS_DATA_WRITE, 8'hAB);
        push_beat(BUS_DATA_WRITE, 8'h55);
        push_beat(BUS_CMD_WRITE, {GRP_COL_LO, 4'h5});
        push_beat(BUS_CMD_WRITE, CMD_MODIFY_ENTER);
        push_beat(BUS_DATA_READ, 8'($urandom));
        push_beat(BUS_DATA_READ, 8'($urandom));
        push_beat(BUS_CMD_WRITE, {GRP_COL_LO, 4'h0});
        push_beat(BUS_DATA_WRITE, 8'h12);
        push_beat(BUS_CMD_WRITE, CMD_MODIFY_LEAVE);
        push_beat(BUS_DATA_READ, 8'($urandom));
        push_beat(BUS_DATA_READ, 8'($urandom));
        push_beat(BUS_CMD_WRITE, CMD_DISP_OFF);
        push_beat(BUS_CMD_WRITE, {GRP_TIMER, 4'hF});
        push_beat(BUS_CMD_WRITE, {GRP_START_3, 4'hF});
        push_beat(BUS_CMD_WRITE, {GRP_CONTR_1, 4'hF});
        push_beat(BUS_CMD_WRITE, {GRP_TRIM, 4'hF});
        push_beat(BUS_CMD_WRITE, CMD_DARK_ON);
        push_beat(BUS_CMD_WRITE, CMD_WHITE_ON);
        push_beat(BUS_CMD_WRITE, CMD_RESET_CONTR);
        push_beat(BUS_CMD_WRITE, CMD_DISP_ON);

        n_random = 0;
        while (n_random < N_RANDOM_BEATS) begin
            kind = $urandom_range(0, 9);
            page = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, N_PAGES - 1))
                                                : 4'($urandom_range(N_PAGES, 15));
            case ($urandom_range(0, 9))
                0, 1:    col = 8'($urandom_range(N_COLS - 12, N_COLS - 1));
                2:       col = 8'($urandom_range(N_COLS, 255));
                default: col = 8'($urandom_range(0, N_COLS - 1));
            endcase
            burst = $urandom_range(1, 10);
            case (kind)
                0, 1, 2: begin
                    push_cursor(page, col);
                    repeat (burst) push_beat(BUS_DATA_WRITE, 8'($urandom));
                    n_random += burst + 3;
                end
                3, 4: begin
                    push_cursor(page, col);
                    repeat (burst + 1) push_beat(BUS_DATA_READ, 8'($urandom));
                    n_random += burst + 4;
                end
                5: begin
                    push_cursor(page, col);
                    push_beat(BUS_CMD_WRITE, CMD_MODIFY_ENTER);
                    repeat (burst) begin
                        push_beat(BUS_DATA_READ, 8'($urandom));
                        push_beat(BUS_DATA_READ, 8'($urandom));
                        if ($urandom_range(0, 3) == 0)
                            push_beat(BUS_CMD_WRITE, {GRP_COL_LO, 4'($urandom)});
                        push_beat(BUS_DATA_WRITE, 8'($urandom));
                    end
                    push_beat(BUS_CMD_WRITE,
                              ($urandom_range(0, 3) == 0) ? CMD_RESET_CONTR : CMD_MODIFY_LEAVE);
                    n_random += 3 * burst + 5;
                end
                6, 7: begin
                    push_beat(BUS_CMD_WRITE, 8'($urandom));
                    n_random++;
                end
                8: begin
                    push_beat(BUS_STATUS, 8'($urandom));
                    push_beat(t_bus_cmd'($urandom_range(0, 3)), 8'($urandom));
                    n_random += 2;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: push_beat(BUS_CMD_WRITE,
                                     $urandom_range(0, 1) ? CMD_DISP_OFF : CMD_DISP_ON);
                        1: push_beat(BUS_CMD_WRITE, {GRP_TIMER, 4'($urandom)});
                        2: push_beat(BUS_CMD_WRITE, {GRP_EFFECT, 4'($urandom)});
                        3: push_beat(BUS_CMD_WRITE, {GRP_TRIM, 4'($urandom)});
                        4: push_beat(BUS_CMD_WRITE,
                                     {$urandom_range(0, 1) ? GRP_SPARE_D : GRP_SPARE_F,
                                      4'($urandom)});
                        default: push_beat(BUS_CMD_WRITE, {2'b01, 6'($urandom)});
                    endcase
                    n_random++;
                end
            endcase
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_beats.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
